FILE: rtl/core/ms_pkg.sv
`timescale 1ns / 1ps

package ms_pkg;

  // Number of values held per set, and the sizes that follow from it
  localparam int Capacity = 64;
  localparam int DataW    = 32;
  localparam int CntW     = $clog2(Capacity + 1);

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value into sorted position
    logic shift;   // move every held value one cell toward the head
  } cell_ctrl_t;

endpackage

FILE: rtl/core/merge_insertion_sorter.sv
`timescale 1ns / 1ps

// Sorting chain for sets of signed 32-bit values.
// Input channel (in_valid_i / in_stall_o): one request per cycle, when not stalled,
// carries value_i and last_item_i. Each value drops straight into its sorted place
// in a row of Capacity cells. Values beyond Capacity are dropped and the set is
// flagged as overflowed.
// The request with last_item_i set starts the drain: the first result is offered on
// the cycle after it is accepted, and while out_stall_i is low results leave at one
// per cycle in ascending order, sorted_value_o from the head cell while the chain
// shifts toward it. last_result_o marks the largest value; overflowed_o is the same
// on all results of a set. The input side is stalled while the chain drains.
// When out_stall_i is high the head cell and all outputs hold.
// Reset empties the chain and clears the count and overflow flag; the block is then
// ready to load at once.
module merge_insertion_sorter import ms_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    last_result_o,
  output logic                    overflowed_o
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic            ovf_q;

  logic signed [DataW-1:0] val_w   [Capacity];
  logic                    valid_w [Capacity];
  logic                    lt_w    [Capacity];

  logic       in_acc, out_acc, full;
  cell_ctrl_t ctrl;

  assign full    = (count_q == CntW'(Capacity));
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // Row of cells, head at index 0
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [DataW-1:0] prev_val, next_val;
    logic                    prev_valid, prev_lt, next_valid;

    if (i == 0) begin : g_head
      // nothing ahead of the head: it counts as filled, so an empty head takes the value
      assign prev_val   = '0;
      assign prev_valid = 1'b1;
      assign prev_lt    = 1'b0;
    end else begin : g_body
      assign prev_val   = val_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_lt    = lt_w[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign next_val   = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_val   = val_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    ms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_val_i   (value_i),
      .prev_val_i  (prev_val),
      .prev_valid_i(prev_valid),
      .prev_lt_i   (prev_lt),
      .next_val_i  (next_val),
      .next_valid_i(next_valid),
      .val_o       (val_w[i]),
      .valid_o     (valid_w[i]),
      .lt_o        (lt_w[i])
    );
  end

  // Load / drain control, count and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + CntW'(1);
            end
            if (last_item_i) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc && last_result_o) begin
            state_q <= ST_LOAD;
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q == ST_DRAIN);
  assign out_valid_o    = (state_q == ST_DRAIN) && valid_w[0];
  assign sorted_value_o = val_w[0];
  assign last_result_o  = !valid_w[1];
  assign overflowed_o   = ovf_q;

endmodule

FILE: rtl/core/ms_cell.sv
`timescale 1ns / 1ps

module ms_cell import ms_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [DataW-1:0] new_val_i,
  // neighbor toward the head (smaller values)
  input  logic signed [DataW-1:0] prev_val_i,
  input  logic                    prev_valid_i,
  input  logic                    prev_lt_i,
  // neighbor toward the tail (larger values)
  input  logic signed [DataW-1:0] next_val_i,
  input  logic                    next_valid_i,
  output logic signed [DataW-1:0] val_o,
  output logic                    valid_o,
  output logic                    lt_o
);

  logic signed [DataW-1:0] val_q, val_d;
  logic                    valid_q, valid_d;
  logic                    lt;
  logic                    take_new;

  // new value sorts before this cell's value (strict, so equal values keep arrival order)
  assign lt       = valid_q && (new_val_i < val_q);
  // first larger cell, or the first empty cell behind a filled one,
  // with no larger cell ahead of it
  assign take_new = !prev_lt_i && (lt || (!valid_q && prev_valid_i));

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (take_new) begin
        val_d   = new_val_i;
        valid_d = 1'b1;
      end else if (prev_lt_i) begin
        // make room: take the neighbor's value
        val_d   = prev_val_i;
        valid_d = prev_valid_i;
      end
    end else if (ctrl_i.shift) begin
      val_d   = next_val_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign lt_o    = lt;

endmodule
